### src/png_container_validator_defines.svh
// Assertion macros shared by the PNG container validator RTL.
`ifndef PNG_CONTAINER_VALIDATOR_DEFINES_SVH
`define PNG_CONTAINER_VALIDATOR_DEFINES_SVH

// Same-cycle implication, disabled while the synchronous reset is held.
`define PNGV_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("pngv assertion failed");

// Next-cycle implication, disabled while the synchronous reset is held.
`define PNGV_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("pngv assertion failed");

`endif

### src/pngv_pkg.sv
// Types, constants and helper functions of the PNG container validator.
`default_nettype none

package pngv_pkg;

    // Chunk walker phases.
    typedef enum logic [1:0] {
        PH_LEN  = 2'd0,
        PH_TYPE = 2'd1,
        PH_DATA = 2'd2,
        PH_CRC  = 2'd3
    } t_phase;

    // Verdict codes.
    typedef logic [2:0] t_status;
    localparam t_status STAT_OK            = 3'd0;
    localparam t_status STAT_INVALID_INPUT = 3'd1;
    localparam t_status STAT_RESOURCE      = 3'd2;
    localparam t_status STAT_UNSUPPORTED   = 3'd3;
    localparam t_status STAT_INVALID_IMAGE = 3'd4;

    // Configuration register indexes.
    typedef logic [1:0] t_cfg_index;
    localparam t_cfg_index CFG_MAX_INPUT_BYTES = 2'd0;
    localparam t_cfg_index CFG_MAX_DIMENSION   = 2'd1;
    localparam t_cfg_index CFG_MAX_PIXELS      = 2'd2;

    // Configuration reset values.
    localparam logic [31:0] RST_MAX_INPUT_BYTES = 32'd1048576;
    localparam logic [31:0] RST_MAX_DIMENSION   = 32'd4096;
    localparam logic [29:0] RST_MAX_PIXELS      = 30'd16777216;

    // CRC-32, reflected form.
    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

    // Chunk type tags, big endian ASCII.
    localparam logic [31:0] TAG_IHDR = 32'h4948_4452;
    localparam logic [31:0] TAG_IDAT = 32'h4944_4154;
    localparam logic [31:0] TAG_IEND = 32'h4945_4E44;
    localparam logic [31:0] TAG_ACTL = 32'h6163_544C;

    // File layout constants.
    localparam logic [31:0] IHDR_LENGTH = 32'd13;

    // The eight bytes of the PNG signature.
    function automatic logic [7:0] sig_byte(input logic [2:0] idx);
        logic [7:0] b;
        case (idx)
            3'd0:    b = 8'h89;
            3'd1:    b = 8'h50;
            3'd2:    b = 8'h4E;
            3'd3:    b = 8'h47;
            3'd4:    b = 8'h0D;
            3'd5:    b = 8'h0A;
            3'd6:    b = 8'h1A;
            default: b = 8'h0A;
        endcase
        return b;
    endfunction

    // Keep the first error seen; later ones are dropped.
    function automatic t_status latch_err(input t_status cur, input t_status code);
        return (cur == STAT_OK) ? code : cur;
    endfunction

endpackage

`default_nettype wire

### src/png_container_validator.sv
// PNG container validator: one verdict per file, given on its last byte.
// Bytes pass the input register; the verdict is held in the result register.
// Throughput: one byte per cycle; a last byte waits only while a verdict is unread.
// The walker, CRC and header checks update once per byte in a single stage.
// Reset is synchronous, active low: limits return to defaults and the stream restarts.
`default_nettype none
`include "png_container_validator_defines.svh"

module png_container_validator #(
    parameter int COUNT_BITS = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Configuration write port
    input  wire logic        i_cfg_wr_en,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_wr_data,
    // Byte input channel
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_last_byte,
    // Verdict output channel
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [2:0]       o_status,
    output logic [31:0]      o_image_width,
    output logic [31:0]      o_image_height
);

    localparam int CNT_W = COUNT_BITS + 1;
    localparam int CMP_W = (CNT_W > 33) ? CNT_W : 33;

    // Configuration registers.
    logic [31:0] r_max_in;
    logic [31:0] r_max_dim;
    logic [29:0] r_max_px;

    // Input stage.
    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_last;
    logic        s2_fire;

    // Stream state and next values.
    logic [CNT_W-1:0]   r_count, n_count;
    pngv_pkg::t_phase   r_phase, n_phase;
    logic [31:0]        r_pos, n_pos, pos_inc;
    logic [31:0]        r_len, n_len;
    logic [31:0]        r_type, n_type;
    logic [31:0]        r_crc, n_crc, crc_upd;
    logic [31:0]        r_stored, n_stored;
    logic [31:0]        r_width, n_width;
    logic [31:0]        r_height, n_height;
    pngv_pkg::t_status  r_err, n_err;
    logic               r_seen_idat, n_seen_idat;
    logic               r_seen_iend, n_seen_iend;
    logic [63:0]        r_pixels;

    // Result register.
    logic               r_out_valid;
    pngv_pkg::t_status  r_out_status, n_out_status;
    logic [31:0]        r_out_width, n_out_width;
    logic [31:0]        r_out_height, n_out_height;

    // Handshake: a last byte moves on only when the result register is free.
    assign s2_fire    = r_in_valid && (!r_in_last || !r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || s2_fire;

    // Configuration writes; indexes past the list are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_in  <= pngv_pkg::RST_MAX_INPUT_BYTES;
            r_max_dim <= pngv_pkg::RST_MAX_DIMENSION;
            r_max_px  <= pngv_pkg::RST_MAX_PIXELS;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                pngv_pkg::CFG_MAX_INPUT_BYTES: r_max_in  <= i_cfg_wr_data;
                pngv_pkg::CFG_MAX_DIMENSION:   r_max_dim <= i_cfg_wr_data;
                pngv_pkg::CFG_MAX_PIXELS:      r_max_px  <= i_cfg_wr_data[29:0];
                default: ;
            endcase
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
        if (o_in_ready && i_in_valid) begin
            r_in_byte <= i_data_byte;
            r_in_last <= i_last_byte;
        end
    end

    // Pixel count product; width and height settle long before it is compared.
    always_ff @(posedge i_clk) begin
        r_pixels <= r_width * r_height;
    end

    // CRC update for the byte in the input register.
    pngv_crc_byte u_crc (
        .i_crc  (r_crc),
        .i_byte (r_in_byte),
        .o_crc  (crc_upd)
    );

    assign pos_inc = r_pos + 32'd1;

    // Per-byte checks, chunk walk and the verdict on the last byte.
    always_comb begin
        n_count      = r_count;
        n_phase      = r_phase;
        n_pos        = r_pos;
        n_len        = r_len;
        n_type       = r_type;
        n_crc        = r_crc;
        n_stored     = r_stored;
        n_width      = r_width;
        n_height     = r_height;
        n_err        = r_err;
        n_seen_idat  = r_seen_idat;
        n_seen_iend  = r_seen_iend;
        n_out_status = r_out_status;
        n_out_width  = r_out_width;
        n_out_height = r_out_height;

        if (s2_fire) begin
            if (!r_count[COUNT_BITS]) begin
                n_count = r_count + CNT_W'(1);
            end
            // Anything after a complete IEND is an error.
            if (r_seen_iend) begin
                n_err = pngv_pkg::latch_err(n_err, pngv_pkg::STAT_INVALID_IMAGE);
            end

            if (r_count < CNT_W'(8)) begin
                // Signature bytes.
                if (r_in_byte != pngv_pkg::sig_byte(r_count[2:0])) begin
                    n_err = pngv_pkg::latch_err(n_err, pngv_pkg::STAT_UNSUPPORTED);
                end
            end else begin
                // IHDR width and height, big endian.
                if (r_count >= CNT_W'(16) && r_count < CNT_W'(20)) begin
                    n_width = {r_width[23:0], r_in_byte};
                end else if (r_count >= CNT_W'(20) && r_count < CNT_W'(24)) begin
                    n_height = {r_height[23:0], r_in_byte};
                end
                if (r_count == CNT_W'(23) && (n_width == 32'd0 || n_height == 32'd0)) begin
                    n_err = pngv_pkg::latch_err(n_err, pngv_pkg::STAT_INVALID_IMAGE);
                end
                // Size limits, checked on the last IHDR CRC byte.
                if (r_count == CNT_W'(32) && (r_width > r_max_dim || r_height > r_max_dim
                        || r_pixels > {34'd0, r_max_px})) begin
                    n_err = pngv_pkg::latch_err(n_err, pngv_pkg::STAT_RESOURCE);
                end

                // Chunk walker.
                case (r_phase)
                    pngv_pkg::PH_LEN: begin
                        n_len = (r_pos == 32'd0) ? {24'd0, r_in_byte}
                                                 : {r_len[23:0], r_in_byte};
                        if (pos_inc == 32'd4) begin
                            n_pos   = 32'd0;
                            n_phase = pngv_pkg::PH_TYPE;
                            n_crc   = pngv_pkg::CRC_INIT;
                            if (r_count == CNT_W'(11) && n_len != pngv_pkg::IHDR_LENGTH) begin
                                n_err = pngv_pkg::latch_err(n_err,
                                                            pngv_pkg::STAT_INVALID_IMAGE);
                            end
                        end else begin
                            n_pos = pos_inc;
                        end
                    end
                    pngv_pkg::PH_TYPE: begin
                        n_type = (r_pos == 32'd0) ? {24'd0, r_in_byte}
                                                  : {r_type[23:0], r_in_byte};
                        n_crc  = crc_upd;
                        if (pos_inc == 32'd4) begin
                            n_pos   = 32'd0;
                            n_phase = (r_len != 32'd0) ? pngv_pkg::PH_DATA : pngv_pkg::PH_CRC;
                            if (r_count == CNT_W'(15) && n_type != pngv_pkg::TAG_IHDR) begin
                                n_err = pngv_pkg::latch_err(n_err,
                                                            pngv_pkg::STAT_INVALID_IMAGE);
                            end
                        end else begin
                            n_pos = pos_inc;
                        end
                    end
                    pngv_pkg::PH_DATA: begin
                        n_crc = crc_upd;
                        if (pos_inc >= r_len) begin
                            n_pos   = 32'd0;
                            n_phase = pngv_pkg::PH_CRC;
                        end else begin
                            n_pos = pos_inc;
                        end
                    end
                    default: begin
                        n_stored = (r_pos == 32'd0) ? {24'd0, r_in_byte}
                                                    : {r_stored[23:0], r_in_byte};
                        if (pos_inc >= 32'd4) begin
                            n_pos   = 32'd0;
                            n_phase = pngv_pkg::PH_LEN;
                            // Chunk complete: CRC, then type-specific rules.
                            if (~r_crc != n_stored) begin
                                n_err = pngv_pkg::latch_err(n_err,
                                                            pngv_pkg::STAT_INVALID_IMAGE);
                            end else if (r_type == pngv_pkg::TAG_ACTL) begin
                                n_err = pngv_pkg::latch_err(n_err,
                                                            pngv_pkg::STAT_UNSUPPORTED);
                            end else begin
                                if (r_type == pngv_pkg::TAG_IDAT) begin
                                    n_seen_idat = 1'b1;
                                end
                                if (r_type == pngv_pkg::TAG_IEND) begin
                                    if (r_len != 32'd0) begin
                                        n_err = pngv_pkg::latch_err(n_err,
                                                    pngv_pkg::STAT_INVALID_IMAGE);
                                    end else begin
                                        n_seen_iend = 1'b1;
                                    end
                                end
                            end
                        end else begin
                            n_pos = pos_inc;
                        end
                    end
                endcase
            end

            // Verdict on the last byte, then the stream starts over.
            if (r_in_last) begin
                if (r_max_in == 32'd0 || r_max_dim == 32'd0 || r_max_px == 30'd0) begin
                    n_out_status = pngv_pkg::STAT_INVALID_INPUT;
                end else if (CMP_W'(n_count) > CMP_W'(r_max_in)
                        || CMP_W'(n_count) > CMP_W'(32'hFFFF_FFFF)) begin
                    n_out_status = pngv_pkg::STAT_RESOURCE;
                end else if (n_err != pngv_pkg::STAT_OK) begin
                    n_out_status = n_err;
                end else if (n_count < CNT_W'(8)) begin
                    n_out_status = pngv_pkg::STAT_UNSUPPORTED;
                end else if (n_count < CNT_W'(33)) begin
                    n_out_status = pngv_pkg::STAT_INVALID_IMAGE;
                end else if (n_phase != pngv_pkg::PH_LEN || n_pos != 32'd0) begin
                    n_out_status = pngv_pkg::STAT_INVALID_IMAGE;
                end else if (!n_seen_idat || !n_seen_iend) begin
                    n_out_status = pngv_pkg::STAT_INVALID_IMAGE;
                end else begin
                    n_out_status = pngv_pkg::STAT_OK;
                end
                n_out_width  = (n_count >= CNT_W'(20)) ? n_width : 32'd0;
                n_out_height = (n_count >= CNT_W'(24)) ? n_height : 32'd0;

                n_count     = '0;
                n_phase     = pngv_pkg::PH_LEN;
                n_pos       = 32'd0;
                n_len       = 32'd0;
                n_type      = 32'd0;
                n_crc       = pngv_pkg::CRC_INIT;
                n_stored    = 32'd0;
                n_width     = 32'd0;
                n_height    = 32'd0;
                n_err       = pngv_pkg::STAT_OK;
                n_seen_idat = 1'b0;
                n_seen_iend = 1'b0;
            end
        end
    end

    // Stream state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_phase     <= pngv_pkg::PH_LEN;
            r_pos       <= 32'd0;
            r_len       <= 32'd0;
            r_type      <= 32'd0;
            r_crc       <= pngv_pkg::CRC_INIT;
            r_stored    <= 32'd0;
            r_width     <= 32'd0;
            r_height    <= 32'd0;
            r_err       <= pngv_pkg::STAT_OK;
            r_seen_idat <= 1'b0;
            r_seen_iend <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_phase     <= n_phase;
            r_pos       <= n_pos;
            r_len       <= n_len;
            r_type      <= n_type;
            r_crc       <= n_crc;
            r_stored    <= n_stored;
            r_width     <= n_width;
            r_height    <= n_height;
            r_err       <= n_err;
            r_seen_idat <= n_seen_idat;
            r_seen_iend <= n_seen_iend;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s2_fire && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        r_out_status <= n_out_status;
        r_out_width  <= n_out_width;
        r_out_height <= n_out_height;
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_out_status;
    assign o_image_width  = r_out_width;
    assign o_image_height = r_out_height;

    // Checks on the block's own logic.
    `PNGV_ASSERT_NOW(a_status_in_range, i_clk, i_rst_n, o_out_valid, o_status <= pngv_pkg::STAT_INVALID_IMAGE)
    `PNGV_ASSERT_NOW(a_ok_has_size, i_clk, i_rst_n, o_out_valid && o_status == pngv_pkg::STAT_OK, o_image_width != 32'd0 && o_image_height != 32'd0)
    `PNGV_ASSERT_NEXT(a_stream_cleared, i_clk, i_rst_n, s2_fire && r_in_last, r_count == '0 && r_err == pngv_pkg::STAT_OK && !r_seen_iend)
    `PNGV_ASSERT_NEXT(a_last_held, i_clk, i_rst_n, r_in_valid && r_in_last && r_out_valid && !i_out_ready, r_in_valid && r_in_last && r_out_valid)

endmodule

`default_nettype wire

### src/pngv_crc_byte.sv
// One-byte update of the reflected CRC-32 used by PNG chunks.
`default_nettype none

module pngv_crc_byte (
    input  wire logic [31:0] i_crc,
    input  wire logic [7:0]  i_byte,
    output logic      [31:0] o_crc
);

    // Eight bit steps of the shift-and-xor division.
    always_comb begin
        logic [31:0] c;
        c = i_crc ^ {24'd0, i_byte};
        for (int k = 0; k < 8; k++) begin
            c = (c >> 1) ^ (c[0] ? pngv_pkg::CRC_POLY : 32'd0);
        end
        o_crc = c;
    end

endmodule

`default_nettype wire

### bench/png_container_validator_tb.sv
// Self-checking testbench for the PNG container validator: byte stream in, verdicts out.
`timescale 1ns / 1ps

module png_container_validator_tb;
    import pngv_pkg::*;

    localparam int          CLK_HALF    = 6;
    localparam int          RESET_CYCLES = 7;
    localparam longint      CYCLE_LIMIT = 300000;
    localparam int          IDLE_PCT    = 12;
    localparam longint      CALM_START  = 3000;
    localparam longint      CALM_END    = 6000;
    localparam int          HOLD_CYCLES = 400;
    localparam int          DRAIN_CYCLES = 20;
    localparam longint unsigned COUNT_CAP = 64'h1_0000_0000;
    localparam logic [7:0]  PNG_SIG [8] = '{8'h89, 8'h50, 8'h4E, 8'h47,
                                            8'h0D, 8'h0A, 8'h1A, 8'h0A};

    // Ways in which a generated file departs from a well-formed one.
    typedef enum int {
        FL_NONE, FL_SIG, FL_IHDR_LEN, FL_ACTL, FL_BAD_CRC, FL_NO_IDAT,
        FL_NO_IEND, FL_IEND_DATA, FL_TRAIL, FL_TRUNC, FL_HUGE_LEN
    } flaw_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } byte_item_t;

    typedef struct packed {
        t_status     status;
        logic [31:0] width;
        logic [31:0] height;
    } verdict_t;

    // DUT signals.
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_wr_en = 1'b0;
    logic [1:0]  i_cfg_index = CFG_MAX_INPUT_BYTES;
    logic [31:0] i_cfg_wr_data = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [7:0]  i_data_byte = '0;
    logic        i_last_byte = 1'b0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [2:0]  o_status;
    logic [31:0] o_image_width;
    logic [31:0] o_image_height;

    // Stimulus and checking bookkeeping.
    byte_item_t  byte_fifo[$];
    verdict_t    verdict_q[$];
    logic [7:0]  file_buf[$];
    logic [7:0]  body[$];
    longint      cycle_cnt = 0;
    int          mismatches = 0;
    int          verdicts_seen = 0;
    bit          in_taken = 1'b0;
    int          hold_left = 0;
    bit          hold_done = 1'b0;

    // Shadow copy of the limit registers.
    logic [31:0] lim_bytes;
    logic [31:0] lim_dim;
    logic [29:0] lim_pix;

    // Shadow copy of the stream state.
    longint unsigned seen_bytes;
    t_phase      walk_phase;
    logic [31:0] walk_pos;
    logic [31:0] walk_len;
    logic [31:0] walk_tag;
    logic [31:0] crc_acc;
    logic [31:0] crc_got;
    logic [31:0] hdr_width;
    logic [31:0] hdr_height;
    t_status     err_code;
    bit          got_idat;
    bit          got_iend;

    png_container_validator u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_data_byte    (i_data_byte),
        .i_last_byte    (i_last_byte),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_status       (o_status),
        .o_image_width  (o_image_width),
        .o_image_height (o_image_height)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    // One byte through the reflected CRC-32.
    function automatic logic [31:0] crc_next(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] r;
        r = c ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
        end
        return r;
    endfunction

    function automatic void flag(input t_status code);
        if (err_code == STAT_OK) begin
            err_code = code;
        end
    endfunction

    function automatic void clear_walk();
        seen_bytes = 0;
        walk_phase = PH_LEN;
        walk_pos   = '0;
        walk_len   = '0;
        walk_tag   = '0;
        crc_acc    = CRC_INIT;
        crc_got    = '0;
        hdr_width  = '0;
        hdr_height = '0;
        err_code   = STAT_OK;
        got_idat   = 1'b0;
        got_iend   = 1'b0;
    endfunction

    // Verdict on a chunk once its CRC field is complete.
    function automatic void close_chunk();
        if (~crc_acc != crc_got) begin
            flag(STAT_INVALID_IMAGE);
        end else if (walk_tag == TAG_ACTL) begin
            flag(STAT_UNSUPPORTED);
        end else begin
            if (walk_tag == TAG_IDAT) begin
                got_idat = 1'b1;
            end
            if (walk_tag == TAG_IEND) begin
                if (walk_len != 0) begin
                    flag(STAT_INVALID_IMAGE);
                end else begin
                    got_iend = 1'b1;
                end
            end
        end
    endfunction

    // Chunk walker from offset 8 on.
    function automatic void walk_step(input longint unsigned off, input logic [7:0] b);
        case (walk_phase)
            PH_LEN: begin
                walk_len = (walk_pos == 0) ? {24'd0, b} : {walk_len[23:0], b};
                walk_pos++;
                if (walk_pos == 4) begin
                    walk_pos   = '0;
                    walk_phase = PH_TYPE;
                    crc_acc    = CRC_INIT;
                    if (off == 11 && walk_len != IHDR_LENGTH) begin
                        flag(STAT_INVALID_IMAGE);
                    end
                end
            end
            PH_TYPE: begin
                walk_tag = (walk_pos == 0) ? {24'd0, b} : {walk_tag[23:0], b};
                crc_acc  = crc_next(crc_acc, b);
                walk_pos++;
                if (walk_pos == 4) begin
                    walk_pos   = '0;
                    walk_phase = (walk_len != 0) ? PH_DATA : PH_CRC;
                    if (off == 15 && walk_tag != TAG_IHDR) begin
                        flag(STAT_INVALID_IMAGE);
                    end
                end
            end
            PH_DATA: begin
                crc_acc = crc_next(crc_acc, b);
                walk_pos++;
                if (walk_pos >= walk_len) begin
                    walk_pos   = '0;
                    walk_phase = PH_CRC;
                end
            end
            default: begin
                crc_got = (walk_pos == 0) ? {24'd0, b} : {crc_got[23:0], b};
                walk_pos++;
                if (walk_pos >= 4) begin
                    walk_pos   = '0;
                    walk_phase = PH_LEN;
                    close_chunk();
                end
            end
        endcase
    endfunction

    // Predicts the effect of one accepted byte; the last byte queues a verdict.
    function automatic void take_byte(input logic [7:0] b, input logic last);
        longint unsigned off;
        logic [63:0]     px;
        verdict_t        v;
        off = seen_bytes;
        if (seen_bytes < COUNT_CAP) begin
            seen_bytes++;
        end
        if (got_iend) begin
            flag(STAT_INVALID_IMAGE);
        end
        if (off < 8) begin
            if (b != PNG_SIG[off[2:0]]) begin
                flag(STAT_UNSUPPORTED);
            end
        end else begin
            if (off >= 16 && off < 20) begin
                hdr_width = {hdr_width[23:0], b};
            end else if (off >= 20 && off < 24) begin
                hdr_height = {hdr_height[23:0], b};
            end
            if (off == 23 && (hdr_width == 0 || hdr_height == 0)) begin
                flag(STAT_INVALID_IMAGE);
            end
            if (off == 32) begin
                px = 64'(hdr_width) * 64'(hdr_height);
                if (hdr_width > lim_dim || hdr_height > lim_dim ||
                    px > 64'(lim_pix) || px > 64'h3FFF_FFFF) begin
                    flag(STAT_RESOURCE);
                end
            end
            walk_step(off, b);
        end
        if (last) begin
            if (lim_bytes == 0 || lim_dim == 0 || lim_pix == 0) begin
                v.status = STAT_INVALID_INPUT;
            end else if (seen_bytes > 64'(lim_bytes) || seen_bytes > 64'hFFFF_FFFF) begin
                v.status = STAT_RESOURCE;
            end else if (err_code != STAT_OK) begin
                v.status = err_code;
            end else if (seen_bytes < 8) begin
                v.status = STAT_UNSUPPORTED;
            end else if (seen_bytes < 33) begin
                v.status = STAT_INVALID_IMAGE;
            end else if (walk_phase != PH_LEN || walk_pos != 0) begin
                v.status = STAT_INVALID_IMAGE;
            end else if (!got_idat || !got_iend) begin
                v.status = STAT_INVALID_IMAGE;
            end else begin
                v.status = STAT_OK;
            end
            v.width  = (seen_bytes >= 20) ? hdr_width : '0;
            v.height = (seen_bytes >= 24) ? hdr_height : '0;
            verdict_q.push_back(v);
            clear_walk();
        end
    endfunction

    function automatic bit idle_now();
        if (cycle_cnt >= CALM_START && cycle_cnt < CALM_END) begin
            return 1'b0;
        end
        return ($urandom_range(99) < IDLE_PCT);
    endfunction

    // File building helpers.
    function automatic void push_word(input logic [31:0] w);
        for (int i = 3; i >= 0; i--) begin
            file_buf.push_back(w[8*i +: 8]);
        end
    endfunction

    function automatic void fill_body(input int n);
        body.delete();
        repeat (n) body.push_back(8'($urandom_range(255)));
    endfunction

    // Appends a chunk carrying the current body, with an optionally broken CRC.
    function automatic void put_chunk(input logic [31:0] tag, input bit bad_crc);
        logic [31:0] c;
        c = CRC_INIT;
        push_word(32'(body.size()));
        push_word(tag);
        for (int i = 3; i >= 0; i--) begin
            c = crc_next(c, tag[8*i +: 8]);
        end
        foreach (body[i]) begin
            file_buf.push_back(body[i]);
            c = crc_next(c, body[i]);
        end
        c = ~c;
        if (bad_crc) begin
            c ^= 32'(1) << $urandom_range(31);
        end
        push_word(c);
    endfunction

    function automatic logic [31:0] pick_tag();
        if ($urandom_range(1)) begin
            return $urandom();
        end
        return {8'($urandom_range(8'h7A, 8'h61)), 8'($urandom_range(8'h7A, 8'h61)),
                8'($urandom_range(8'h5A, 8'h41)), 8'($urandom_range(8'h7A, 8'h61))};
    endfunction

    // Builds one file into file_buf with the given header size and flaw.
    function automatic void build_png(input flaw_t flaw, input logic [31:0] w,
                                      input logic [31:0] h);
        int idx;
        int cut;
        file_buf.delete();
        for (int i = 0; i < 8; i++) begin
            file_buf.push_back(PNG_SIG[i]);
        end
        if (flaw == FL_SIG) begin
            idx = $urandom_range(7);
            file_buf[idx] = file_buf[idx] ^ 8'(1 << $urandom_range(7));
        end
        // Header chunk: width, height and five random attribute bytes.
        body.delete();
        for (int i = 3; i >= 0; i--) body.push_back(w[8*i +: 8]);
        for (int i = 3; i >= 0; i--) body.push_back(h[8*i +: 8]);
        repeat (5) body.push_back(8'($urandom_range(255)));
        if (flaw == FL_IHDR_LEN) begin
            if ($urandom_range(1)) begin
                void'(body.pop_back());
            end else begin
                body.push_back(8'($urandom_range(255)));
            end
        end
        put_chunk(TAG_IHDR, 1'b0);
        // Ancillary chunks with random names.
        repeat ($urandom_range(2)) begin
            fill_body($urandom_range(6));
            put_chunk(pick_tag(), 1'b0);
        end
        if (flaw == FL_ACTL) begin
            fill_body(8);
            put_chunk(TAG_ACTL, 1'b0);
        end
        if (flaw != FL_NO_IDAT) begin
            fill_body($urandom_range(10));
            put_chunk(TAG_IDAT, flaw == FL_BAD_CRC);
            if ($urandom_range(2) == 0) begin
                fill_body($urandom_range(10));
                put_chunk(TAG_IDAT, 1'b0);
            end
        end
        // A huge declared length leaves the file ending inside the data.
        if (flaw == FL_HUGE_LEN) begin
            push_word($urandom() | 32'h0000_1000);
            push_word(($urandom_range(1)) ? TAG_IDAT : pick_tag());
            repeat ($urandom_range(5, 1)) file_buf.push_back(8'($urandom_range(255)));
            return;
        end
        if (flaw != FL_NO_IEND) begin
            fill_body((flaw == FL_IEND_DATA) ? $urandom_range(3, 1) : 0);
            put_chunk(TAG_IEND, 1'b0);
        end
        if (flaw == FL_TRAIL) begin
            repeat ($urandom_range(3, 1)) file_buf.push_back(8'($urandom_range(255)));
        end
        if (flaw == FL_TRUNC) begin
            cut = $urandom_range(file_buf.size() - 1, 1);
            while (file_buf.size() > cut) void'(file_buf.pop_back());
        end
    endfunction

    // Queues file_buf for the driver, marking its final byte.
    function automatic void send_file();
        foreach (file_buf[i]) begin
            byte_fifo.push_back('{data: file_buf[i], last: (i == file_buf.size() - 1)});
        end
    endfunction

    function automatic logic [31:0] pick_dim();
        logic [31:0] cap;
        int          r;
        cap = (lim_dim == 0 || lim_dim > 300) ? 32'd300 : lim_dim;
        r   = $urandom_range(99);
        if (r < 4) return '0;
        if (r < 12) return $urandom();
        if (r < 17) return lim_dim;
        if (r < 22) return lim_dim + 1;
        return $urandom_range(cap, 1);
    endfunction

    // Mostly well-formed files with random content, plus flaws and noise.
    function automatic void random_file();
        int    r;
        flaw_t flaw;
        r = $urandom_range(99);
        if (r < 10) begin
            file_buf.delete();
            if ($urandom_range(1)) begin
                for (int i = 0; i < 8; i++) file_buf.push_back(PNG_SIG[i]);
            end
            repeat ($urandom_range(40, 1)) file_buf.push_back(8'($urandom_range(255)));
        end else begin
            flaw = (r < 65) ? FL_NONE : flaw_t'($urandom_range(FL_HUGE_LEN, FL_SIG));
            build_png(flaw, pick_dim(), pick_dim());
        end
        send_file();
    endfunction

    function automatic logic [31:0] pick_limit(input logic [31:0] full,
                                               input logic [31:0] small_hi);
        int r;
        r = $urandom_range(99);
        if (r < 8) return '0;
        if (r < 25) return full;
        if (r < 45) return $urandom() & full;
        return $urandom_range(small_hi, 1);
    endfunction

    task automatic write_reg(input t_cfg_index idx, input logic [31:0] val);
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_index   <= idx;
        i_cfg_wr_data <= val;
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        i_cfg_wr_data <= $urandom();
    endtask

    task automatic write_limits(input logic [31:0] nbytes, input logic [31:0] ndim,
                                input logic [31:0] npix);
        write_reg(CFG_MAX_INPUT_BYTES, nbytes);
        write_reg(CFG_MAX_DIMENSION, ndim);
        write_reg(CFG_MAX_PIXELS, npix);
    endtask

    // Waits until every queued byte is taken and every verdict has come back.
    task automatic settle();
        @(negedge i_clk);
        while (byte_fifo.size() != 0 || i_in_valid || verdict_q.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (8) @(negedge i_clk);
    endtask

    task automatic run_random(input int n);
        repeat (n) random_file();
        settle();
    endtask

    // Acceptance of bytes and register writes feeds the predictor.
    always @(posedge i_clk) begin
        in_taken = i_in_valid && o_in_ready;
        if (i_rst_n) begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_MAX_INPUT_BYTES: lim_bytes = i_cfg_wr_data;
                    CFG_MAX_DIMENSION:   lim_dim   = i_cfg_wr_data;
                    CFG_MAX_PIXELS:      lim_pix   = i_cfg_wr_data[29:0];
                    default: ;
                endcase
            end
            if (in_taken) begin
                take_byte(i_data_byte, i_last_byte);
            end
        end
    end

    // Byte driver: holds an offered item until taken, then offers the next.
    always @(negedge i_clk) begin
        byte_item_t it;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (i_in_valid && !in_taken) begin
            // Item still waiting for the block.
        end else if (byte_fifo.size() != 0 && !idle_now()) begin
            it = byte_fifo.pop_front();
            i_data_byte <= it.data;
            i_last_byte <= it.last;
            i_in_valid  <= 1'b1;
        end else begin
            i_in_valid <= 1'b0;
        end
    end

    // Verdict receiver with random stalls and one long hold-off.
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left   <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else if (!hold_done && byte_fifo.size() > 150 && verdicts_seen >= 5) begin
            hold_done   <= 1'b1;
            hold_left   <= HOLD_CYCLES;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= !idle_now();
        end
    end

    // Verdict checker against the oldest prediction.
    always @(posedge i_clk) begin
        verdict_t v;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            verdicts_seen++;
            if (verdict_q.size() == 0) begin
                $error("unexpected verdict: status %0d width %0h height %0h",
                       o_status, o_image_width, o_image_height);
                mismatches++;
            end else begin
                v = verdict_q.pop_front();
                if (o_status !== v.status) begin
                    $error("status: expected %0d, actual %0d", v.status, o_status);
                    mismatches++;
                end
                if (o_image_width !== v.width) begin
                    $error("image_width: expected %0h, actual %0h", v.width, o_image_width);
                    mismatches++;
                end
                if (o_image_height !== v.height) begin
                    $error("image_height: expected %0h, actual %0h", v.height,
                           o_image_height);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Test sequence.
    initial begin
        lim_bytes = RST_MAX_INPUT_BYTES;
        lim_dim   = RST_MAX_DIMENSION;
        lim_pix   = RST_MAX_PIXELS;
        clear_walk();
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed files under the reset limits.
        build_png(FL_NONE, 32'd1, 32'd1);               send_file();
        file_buf = '{8'h00};                            send_file();
        file_buf = '{8'hFF, 8'h50};                     send_file();
        file_buf.delete();
        for (int i = 0; i < 8; i++) file_buf.push_back(PNG_SIG[i]);
        send_file();
        build_png(FL_NONE, 32'd7, 32'd9);
        while (file_buf.size() > 22) void'(file_buf.pop_back());
        send_file();
        build_png(FL_SIG, 32'd10, 32'd10);              send_file();
        build_png(FL_IHDR_LEN, 32'd10, 32'd10);         send_file();
        build_png(FL_NONE, 32'd0, 32'd5);               send_file();
        build_png(FL_NONE, 32'd5, 32'd0);               send_file();
        build_png(FL_NONE, 32'd4097, 32'd1);            send_file();
        build_png(FL_NONE, 32'd4096, 32'd4096);         send_file();
        build_png(FL_NONE, 32'd4096, 32'd4097);         send_file();
        build_png(FL_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF); send_file();
        for (int f = FL_ACTL; f <= FL_HUGE_LEN; f++) begin
            build_png(flaw_t'(f), 32'd8, 32'd8);
            send_file();
        end
        settle();

        // Widest limits, each limit at zero, a one-byte size limit, then small limits.
        write_limits(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h3FFF_FFFF);
        build_png(FL_NONE, 32'h0000_8000, 32'h0000_8000); send_file();
        build_png(FL_NONE, 32'h0000_8000, 32'h0000_8001); send_file();
        run_random(8);
        write_reg(CFG_MAX_INPUT_BYTES, 32'd0);
        run_random(3);
        write_limits(32'hFFFF_FFFF, 32'd0, 32'h3FFF_FFFF);
        run_random(3);
        write_limits(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0);
        run_random(3);
        write_limits(32'd1, 32'd4096, 32'd1000);
        run_random(3);
        write_limits(32'd70, 32'd16, 32'd100);
        run_random(8);

        // Random limit settings, each with a batch of random files.
        repeat (9) begin
            write_limits(pick_limit(32'hFFFF_FFFF, 32'd200),
                         pick_limit(32'hFFFF_FFFF, 32'd300),
                         pick_limit(32'h3FFF_FFFF, 32'd50000));
            run_random(8);
        end

        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (mismatches == 0 && verdict_q.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

### filelist.f
+incdir+src
src/pngv_pkg.sv
src/pngv_crc_byte.sv
src/png_container_validator.sv
bench/png_container_validator_tb.sv
